// ===== rtl/stg_pkg.sv =====
// Shared types and constants for the square-wave tone generator.
// No dependencies; imported by every module of the block.
package stg_pkg;

    localparam int PIN_COUNT = 64;

    localparam int PIN_W    = 6;
    localparam int FREQ_W   = 22;
    localparam int DUR_W    = 32;
    localparam int PER_W    = 17;
    localparam int FEFF_W   = 21;
    localparam int DIV_W    = 32;
    localparam int DVSR_W   = 22;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int RECIP_W   = 29;
    localparam int RECIP_SHIFT = 38;

    localparam logic [PIN_W:0]      PIN_LIMIT       = (PIN_W + 1)'(PIN_COUNT);
    // 4 MHz carrier / 2: half-period and effective frequency both divide this
    localparam logic [DIV_W-1:0]    HALF_CARRIER    = 32'd2000000;
    localparam logic [PER_W-1:0]    MAX_HALF_PERIOD = 17'h10000;
    localparam logic [DUR_W-1:0]    ENDLESS_BUDGET  = 32'hffffffff;
    // ceil(2^38 / 1000): (x * MS_RECIP) >> 38 is x / 1000 for any 32-bit x
    localparam logic [RECIP_W-1:0]  MS_RECIP        = 29'd274877907;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_STOP  = 2'd2
    } stg_cmd_code_t;

    typedef struct packed {
        logic [1:0]        command;
        logic [PIN_W-1:0]  pin;
        logic [FREQ_W-1:0] frequency;
        logic [DUR_W-1:0]  duration_ms;
    } stg_in_t;

    typedef struct packed {
        logic             active;
        logic [PIN_W-1:0] active_pin;
        logic             level;
    } stg_out_t;

    typedef enum logic {
        DSEL_PER,
        DSEL_FEFF
    } stg_dsel_t;

    // controller -> datapath
    typedef struct packed {
        logic      latch;
        logic      step;
        logic      div_go;
        stg_dsel_t div_sel;
        logic      take_per;
        logic      take_feff;
        logic      mul;
        logic      commit;
    } stg_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic start_ok;
        logic div_done;
    } stg_sts_t;

endpackage

// ===== rtl/stg_div.sv =====
// Radix-2 restoring divider, one quotient bit per clock.
// Depends on stg_pkg for widths.
module stg_div
    import stg_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              go,
    input  logic [DIV_W-1:0]  dividend,
    input  logic [DVSR_W-1:0] divisor,
    output logic              done,
    output logic [DIV_W-1:0]  quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVSR_W-1:0]    rem_reg, rem_next;
    logic [DVSR_W-1:0]    dvsr_reg, dvsr_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;

    logic [DVSR_W:0] shifted;
    logic [DVSR_W:0] diff;
    logic            fits;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign diff    = shifted - {1'b0, dvsr_reg};
    assign fits    = (shifted >= {1'b0, dvsr_reg});

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;
        if (go) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvsr_next = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the low bits suffice
            rem_next = fits ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/stg_dp.sv =====
// Datapath: tone state, start-parameter arithmetic and the result register.
// Depends on stg_pkg and stg_div.
module stg_dp
    import stg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  stg_in_t  s_data,
    input  stg_ctl_t ctl,
    output stg_sts_t sts,
    output stg_out_t out_data
);

    // tone state
    logic              running_reg, running_next;
    logic [PIN_W-1:0]  current_pin_reg, current_pin_next;
    logic              pin_level_reg, pin_level_next;
    logic [PER_W-1:0]  half_period_reg, half_period_next;
    logic [PER_W-1:0]  tick_counter_reg, tick_counter_next;
    logic [DUR_W-1:0]  toggles_left_reg, toggles_left_next;

    // start-command working registers
    logic [PIN_W-1:0]  pin_reg;
    logic [FREQ_W-1:0] freq_reg;
    logic [DUR_W-1:0]  dur_reg;
    logic [PER_W-1:0]  per_reg, per_next;
    logic [FEFF_W-1:0] feff_reg;
    logic [DIV_W-1:0]  prod_reg;
    stg_out_t          out_reg, out_next;

    logic [DVSR_W-1:0] divisor;
    logic [DIV_W-1:0]  div_quo;
    logic              div_done;
    logic [DIV_W-1:0]  mul_lo;
    logic [DIV_W+RECIP_W-1:0] recip_prod;
    logic [PER_W-1:0]  tick_inc;
    logic [DUR_W-1:0]  budget;
    logic              pin_ok;

    assign pin_ok = ({1'b0, s_data.pin} < PIN_LIMIT);

    assign sts.start_ok = (s_data.command == CMD_START) && (s_data.frequency != '0) && pin_ok;
    assign sts.div_done = div_done;

    // both divider passes divide the half carrier rate
    assign divisor = (ctl.div_sel == DSEL_FEFF) ? DVSR_W'(per_reg) : freq_reg;

    stg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (ctl.div_go),
        .dividend (HALF_CARRIER),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // half-period clamp to 1..65536
    always_comb begin
        if (div_quo == '0) begin
            per_next = PER_W'(1);
        end else if (div_quo > DIV_W'(MAX_HALF_PERIOD)) begin
            per_next = MAX_HALF_PERIOD;
        end else begin
            per_next = div_quo[PER_W-1:0];
        end
    end

    // only the low 32 bits of feff * duration matter (mod 2^32)
    assign mul_lo   = DIV_W'({{(DIV_W - FEFF_W){1'b0}}, feff_reg} * dur_reg);
    // budget / 1000 by reciprocal multiply
    assign recip_prod = (DIV_W + RECIP_W)'(prod_reg) * (DIV_W + RECIP_W)'(MS_RECIP);
    assign tick_inc = tick_counter_reg + PER_W'(1);
    assign budget   = (dur_reg == '0) ? ENDLESS_BUDGET
                                      : DUR_W'(recip_prod[DIV_W+RECIP_W-1:RECIP_SHIFT]);

    always_comb begin
        running_next      = running_reg;
        current_pin_next  = current_pin_reg;
        pin_level_next    = pin_level_reg;
        half_period_next  = half_period_reg;
        tick_counter_next = tick_counter_reg;
        toggles_left_next = toggles_left_reg;

        if (ctl.step) begin
            if (s_data.command == CMD_TICK) begin
                if (running_reg) begin
                    if (tick_inc < half_period_reg) begin
                        tick_counter_next = tick_inc;
                    end else begin
                        tick_counter_next = '0;
                        if (toggles_left_reg != '0) begin
                            pin_level_next = ~pin_level_reg;
                            if (toggles_left_reg != ENDLESS_BUDGET) begin
                                toggles_left_next = toggles_left_reg - DUR_W'(1);
                            end
                        end else begin
                            running_next   = 1'b0;
                            pin_level_next = 1'b0;
                        end
                    end
                end
            end else if (s_data.command == CMD_STOP) begin
                if (pin_ok && running_reg && (current_pin_reg == s_data.pin)) begin
                    running_next      = 1'b0;
                    pin_level_next    = 1'b0;
                    tick_counter_next = '0;
                end
            end
        end

        if (ctl.commit) begin
            half_period_next  = per_reg;
            tick_counter_next = '0;
            toggles_left_next = budget;
            // new pin (or idle): restart low; same pin keeps its level
            if (!running_reg || (current_pin_reg != pin_reg)) begin
                running_next     = 1'b1;
                current_pin_next = pin_reg;
                pin_level_next   = 1'b0;
            end
        end

        out_next.active     = running_next;
        out_next.active_pin = current_pin_next;
        out_next.level      = pin_level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_reg      <= 1'b0;
            current_pin_reg  <= '0;
            pin_level_reg    <= 1'b0;
            half_period_reg  <= PER_W'(1);
            tick_counter_reg <= '0;
            toggles_left_reg <= '0;
        end else begin
            running_reg      <= running_next;
            current_pin_reg  <= current_pin_next;
            pin_level_reg    <= pin_level_next;
            half_period_reg  <= half_period_next;
            tick_counter_reg <= tick_counter_next;
            toggles_left_reg <= toggles_left_next;
        end
        if (ctl.latch) begin
            pin_reg  <= s_data.pin;
            freq_reg <= s_data.frequency;
            dur_reg  <= s_data.duration_ms;
        end
        if (ctl.take_per) begin
            per_reg <= per_next;
        end
        if (ctl.take_feff) begin
            feff_reg <= div_quo[FEFF_W-1:0];
        end
        if (ctl.mul) begin
            prod_reg <= {mul_lo[DIV_W-3:0], 2'b00};
        end
        if (ctl.step || ctl.commit) begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/stg_ctrl.sv =====
// Controller FSM: handshakes and sequencing of the start-command arithmetic.
// Depends on stg_pkg.
module stg_ctrl
    import stg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  stg_sts_t sts,
    output stg_ctl_t ctl
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_FEFF_GO,
        ST_FEFF_WAIT,
        ST_MUL,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        ctl         = '0;
        ctl.div_sel = DSEL_PER;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (sts.start_ok) begin
                        ctl.latch  = 1'b1;
                        state_next = ST_PER_GO;
                    end else begin
                        ctl.step = 1'b1;
                    end
                end
            end
            ST_PER_GO: begin
                ctl.div_go = 1'b1;
                state_next = ST_PER_WAIT;
            end
            ST_PER_WAIT: begin
                if (sts.div_done) begin
                    ctl.take_per = 1'b1;
                    state_next   = ST_FEFF_GO;
                end
            end
            ST_FEFF_GO: begin
                ctl.div_go  = 1'b1;
                ctl.div_sel = DSEL_FEFF;
                state_next  = ST_FEFF_WAIT;
            end
            ST_FEFF_WAIT: begin
                if (sts.div_done) begin
                    ctl.take_feff = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL: begin
                ctl.mul    = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (out_free) begin
                    ctl.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
        m_valid_next = (m_valid_reg && !m_ready) || ctl.step || ctl.commit;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

// ===== rtl/square_wave_tone_generator_core.sv =====
// Square-wave tone generator driven by 4 MHz carrier-tick transfers. Every input transfer
// (carrier tick, start, stop) yields exactly one result transfer reporting active, active_pin
// and level after the command is applied. Carrier ticks, stop commands and ignored starts
// (frequency 0) are applied in the accept cycle, so ticks stream at one per clock while the
// result side keeps up; the result register lets the next transfer in while the current
// result is taken. An accepted start runs through two passes of a single shared bit-serial
// divider (half period, effective frequency), a multiply step for feff * duration_ms * 4 and
// a commit step that divides the budget by 1000 with a reciprocal multiply; commit also
// waits while a result is still held, and no input is accepted meanwhile. The half period
// is clamped to 1..65536 carrier ticks, the budget is feff * duration_ms * 4 with 32-bit
// wrap, divided by 1000; duration 0 runs endlessly.
// Depends on stg_pkg, stg_ctrl, stg_dp (and stg_div below it).
module square_wave_tone_generator_core
    import stg_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  stg_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output stg_out_t m_data
);

    stg_ctl_t ctl;
    stg_sts_t sts;

    // FSM: owns both handshakes and sequences the divider passes
    stg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .ctl     (ctl)
    );

    // tone state, divider, multiplier and result register
    stg_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_data   (s_data),
        .ctl      (ctl),
        .sts      (sts),
        .out_data (m_data)
    );

`ifndef SYNTHESIS
    // non-start commands finish in the accept cycle
    a_simple_cmd_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.command != CMD_START)) |=> m_valid)
        else $error("no result after a single-cycle command");

    // an accepted nonzero-frequency start leaves no result behind and blocks input the next cycle
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.command == CMD_START) && (s_data.frequency != '0))
        |=> (!m_valid && !s_ready))
        else $error("start command did not enter the divide sequence");

    // an idle generator reports its pin low in every result
    a_idle_low: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.active || !m_data.level))
        else $error("level high while tone inactive");
`endif

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for square_wave_tone_generator_core: directed table, then random
// commands in idle/stall phases; results checked against typed rows or a tone predictor.
// Depends on stg_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
    import stg_pkg::*;

    localparam logic [1:0]  CMD_UNUSED   = 2'd3;   // not decoded by the block
    localparam logic [31:0] CARRIER_HZ   = 32'd4000000;
    localparam logic [31:0] MS_PER_S     = 32'd1000;
    localparam logic [31:0] PER_CLAMP    = 32'd65536;
    localparam int          N_DIRECTED   = 24;
    localparam int          N_RANDOM     = 950;
    localparam int          HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int          QUIET_LIMIT  = 3000;   // cycles with no transfer at all
    localparam int          DRAIN_CYCLES = 110;    // covers one start

    // One directed row; res is used only where typed is set
    typedef struct packed {
        logic [1:0]        cmd;
        logic [PIN_W-1:0]  pin;
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
        logic              typed;
        stg_out_t          res;
    } tone_row_t;

    logic     aclk;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    stg_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    stg_out_t m_data;

    // Predicted tone state, reset values
    logic              tone_on       = 1'b0;
    logic [PIN_W-1:0]  tone_pin      = '0;
    logic              tone_lvl      = 1'b0;
    logic [16:0]       tone_half_per = 17'd1;
    logic [16:0]       tone_ticks    = '0;
    logic [31:0]       tone_budget   = '0;

    stg_out_t tone_state_q[$];     // reported states still to come
    stg_out_t want_res;
    int       mismatch_cnt   = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    bit       hold_req       = 1'b0;
    int       quiet_cycles;

    // Directed part. Typed rows are plain to read off: idle after reset, period-1
    // tones at the top frequency, ignored starts and stops, unknown command, a
    // budget that wraps to zero (8e6 * 2^23 is a multiple of 2^32), pin takeover.
    tone_row_t dir_rows [0:N_DIRECTED-1] = '{
        '{CMD_TICK,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b0, 6'd0,  1'b0}},
        '{CMD_STOP,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b0, 6'd0,  1'b0}},
        '{CMD_START,  6'd63, 22'd4000000, 32'd0,          1'b1, '{1'b1, 6'd63, 1'b0}},
        '{CMD_TICK,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b1, 6'd63, 1'b1}},
        '{CMD_TICK,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b1, 6'd63, 1'b0}},
        '{CMD_TICK,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b1, 6'd63, 1'b1}},
        '{CMD_START,  6'd10, 22'd0,       32'd5,          1'b1, '{1'b1, 6'd63, 1'b1}},
        '{CMD_STOP,   6'd10, 22'd0,       32'd0,          1'b1, '{1'b1, 6'd63, 1'b1}},
        '{CMD_UNUSED, 6'd63, 22'd0,       32'd0,          1'b1, '{1'b1, 6'd63, 1'b1}},
        '{CMD_START,  6'd63, 22'h3fffff,  32'd0,          1'b1, '{1'b1, 6'd63, 1'b1}},
        '{CMD_TICK,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b1, 6'd63, 1'b0}},
        '{CMD_STOP,   6'd63, 22'd0,       32'd0,          1'b1, '{1'b0, 6'd63, 1'b0}},
        '{CMD_START,  6'd0,  22'd4000000, 32'h00800000,   1'b1, '{1'b1, 6'd0,  1'b0}},
        '{CMD_TICK,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b0, 6'd0,  1'b0}},
        '{CMD_START,  6'd5,  22'd1,       32'hffffffff,   1'b1, '{1'b1, 6'd5,  1'b0}},
        '{CMD_START,  6'd6,  22'd2000000, 32'd1,          1'b1, '{1'b1, 6'd6,  1'b0}},
        '{CMD_TICK,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b1, 6'd6,  1'b1}},
        '{CMD_START,  6'd6,  22'd1000000, 32'd0,          1'b1, '{1'b1, 6'd6,  1'b1}},
        '{CMD_TICK,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b1, 6'd6,  1'b1}},
        '{CMD_TICK,   6'd0,  22'd0,       32'd0,          1'b1, '{1'b1, 6'd6,  1'b0}},
        '{CMD_START,  6'd33, 22'd123457,  32'h12345678,   1'b0, '0},
        '{CMD_STOP,   6'd6,  22'd0,       32'd0,          1'b0, '0},
        '{CMD_UNUSED, 6'd63, 22'h3fffff,  32'hffffffff,   1'b0, '0},
        '{CMD_STOP,   6'd33, 22'd0,       32'd0,          1'b0, '0}
    };

    square_wave_tone_generator_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Half period in carrier ticks, clamped to 1..65536 (freq must be nonzero)
    function automatic logic [16:0] half_period_for(logic [FREQ_W-1:0] f);
        logic [31:0] q;
        q = CARRIER_HZ / (32'd2 * 32'(f));
        if (q < 32'd1)
            q = 32'd1;
        if (q > PER_CLAMP)
            q = PER_CLAMP;
        return q[16:0];
    endfunction

    function automatic logic [31:0] eff_freq(logic [16:0] per);
        return CARRIER_HZ / (32'd2 * 32'(per));
    endfunction

    function void silence();
        tone_on    = 1'b0;
        tone_lvl   = 1'b0;
        tone_ticks = '0;
    endfunction

    // Apply one accepted command to the predicted state, return the reported state
    function stg_out_t tone_step(stg_in_t it);
        logic [16:0] per;
        logic [31:0] feff;
        logic [31:0] prod;
        case (it.command)
            CMD_TICK: begin
                if (tone_on) begin
                    tone_ticks = tone_ticks + 17'd1;
                    if (tone_ticks >= tone_half_per) begin
                        tone_ticks = '0;
                        if (tone_budget != 32'd0) begin
                            tone_lvl = ~tone_lvl;
                            if (tone_budget != ENDLESS_BUDGET)
                                tone_budget = tone_budget - 32'd1;
                        end else begin
                            silence();
                        end
                    end
                end
            end
            CMD_START: begin
                if (it.frequency != '0 && 32'(it.pin) < PIN_COUNT) begin
                    if (tone_on && tone_pin != it.pin)
                        silence();
                    per  = half_period_for(it.frequency);
                    feff = eff_freq(per);
                    prod = feff * it.duration_ms * 32'd4;   // wraps at 32 bits
                    tone_budget   = (it.duration_ms != '0) ? prod / MS_PER_S : ENDLESS_BUDGET;
                    tone_half_per = per;
                    tone_ticks    = '0;
                    if (!tone_on) begin
                        tone_on  = 1'b1;
                        tone_pin = it.pin;
                        tone_lvl = 1'b0;
                    end
                end
            end
            CMD_STOP: begin
                if (tone_on && tone_pin == it.pin)
                    silence();
            end
            default: ;
        endcase
        return '{tone_on, tone_pin, tone_lvl};
    endfunction

    // Duration whose wrapped product feff*dur*4 is 2^t * j for a small j, so the
    // tone runs out after a handful of toggles. j = 0 gives a zero budget.
    function automatic logic [31:0] short_tone_dur(logic [16:0] per);
        logic [31:0] a;
        logic [31:0] m;
        logic [31:0] inv;
        logic [31:0] j;
        int          t;
        a = eff_freq(per) * 32'd4;
        t = 0;
        while (a[t] == 1'b0)
            t++;
        m   = a >> t;
        inv = m;                        // odd m: good to 3 bits, Newton doubles it
        repeat (5) inv = inv * (32'd2 - m * inv);
        j   = $urandom_range(8000 >> t, 0);
        inv = (inv * j) & ((32'd1 << (32 - t)) - 32'd1);
        return (inv == '0) ? (32'd1 << (32 - t)) : inv;
    endfunction

    // Offer one command: optional idle gap, then hold valid until the transfer
    task offer(input stg_in_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Receiver: random stalls, plus a long hold-off on request so the
    // block backs up and stalls its input side
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Result checker: oldest expectation against each result transfer
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (tone_state_q.size() == 0) begin
                $error("result transfer with no expectation: %p", m_data);
                mismatch_cnt++;
            end else begin
                want_res = tone_state_q.pop_front();
                if (m_data.active !== want_res.active) begin
                    $error("active: expected %0d, got %0d", want_res.active, m_data.active);
                    mismatch_cnt++;
                end
                if (m_data.active_pin !== want_res.active_pin) begin
                    $error("active_pin: expected %0d, got %0d",
                           want_res.active_pin, m_data.active_pin);
                    mismatch_cnt++;
                end
                if (m_data.level !== want_res.level) begin
                    $error("level: expected %0d, got %0d", want_res.level, m_data.level);
                    mismatch_cnt++;
                end
            end
        end
    end

    // Watchdog: too long without any transfer on either side
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        stg_in_t  it;
        stg_out_t res;
        int       i;
        int       r;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows, no idling
        for (i = 0; i < N_DIRECTED; i++) begin
            it.command     = dir_rows[i].cmd;
            it.pin         = dir_rows[i].pin;
            it.frequency   = dir_rows[i].freq;
            it.duration_ms = dir_rows[i].dur;
            offer(it);
            res = tone_step(it);
            tone_state_q.push_back(dir_rows[i].typed ? dir_rows[i].res : res);
        end

        // Random part: mostly carrier ticks, with starts that mostly pick short
        // periods and small budgets so tones really toggle out and stop
        for (i = 0; i < N_RANDOM; i++) begin
            case (i / 200)
                1:       begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 58; end
                3:       begin send_idle_pct = 38; recv_stall_pct = 38; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            if (i == 100 || i == 500)
                hold_req = 1'b1;

            it.pin         = PIN_W'($urandom_range(63));
            it.frequency   = FREQ_W'($urandom_range(22'h3fffff, 0));
            it.duration_ms = $urandom;
            r = $urandom_range(99);
            if (r < 75) begin
                it.command = CMD_TICK;
            end else if (r < 85) begin
                it.command = CMD_START;
                if ($urandom_range(1) == 1)
                    it.pin = tone_pin;
                r = $urandom_range(99);
                if (r < 60) begin
                    it.frequency   = FREQ_W'($urandom_range(22'h3fffff, 250000)); // period 1..8
                    it.duration_ms = short_tone_dur(half_period_for(it.frequency));
                end else if (r < 75) begin
                    it.frequency   = FREQ_W'($urandom_range(22'h3fffff, 1));
                    it.duration_ms = '0;                                  // endless
                end else if (r < 95) begin
                    it.frequency   = FREQ_W'($urandom_range(22'h3fffff, 1));
                end else begin
                    it.frequency   = '0;                                  // ignored start
                end
            end else if (r < 95) begin
                it.command = CMD_STOP;
                if ($urandom_range(9) < 7)
                    it.pin = tone_pin;
            end else begin
                it.command = CMD_UNUSED;
            end
            offer(it);
            tone_state_q.push_back(tone_step(it));
        end
        s_valid <= 1'b0;

        // Drain, then watch a little longer for stray results
        while (tone_state_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/stg_pkg.sv
rtl/stg_div.sv
rtl/stg_dp.sv
rtl/stg_ctrl.sv
rtl/square_wave_tone_generator_core.sv
test/tb_top.sv
